@@ hw/rtl/sem_pkg.sv @@
// shared types and constants for the sobel edge magnitude block
package sem_pkg;

  localparam int PIX_W      = 8;
  localparam int RGB_W      = 3 * PIX_W;
  localparam int GRAD_W     = 12;
  localparam int SUM_W      = 21;
  localparam int MAG_W      = 8;
  localparam int CFG_W_W    = 11;
  localparam int CFG_H_W    = 13;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 13;
  localparam int ROW_W      = 13;

  localparam int MAX_WIDTH_DEF = 1024;

  localparam logic [CFG_H_W-1:0] MAX_HEIGHT   = CFG_H_W'(4096);
  localparam logic [CFG_W_W-1:0] WIDTH_RST    = CFG_W_W'(1024);
  localparam logic [CFG_H_W-1:0] HEIGHT_RST   = CFG_H_W'(768);

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIN,
    ST_GRAD,
    ST_SQR,
    ST_ROOT,
    ST_OUT
  } sem_state_t;

endpackage

@@ hw/rtl/sobel_edge_magnitude_rgb.sv @@
// streaming 3x3 sobel edge magnitude on rgb pixels, top level
//
// input channel: one beat per pixel in raster order (in_action = pixel), or a
// flush beat that drains the outputs still owed after the last pixel.
// output channel: one beat per pixel of the frame, out_frame_last on the last.
// output for pixel (r,c) comes with the input beat numbered r*W+c+W+1, so
// results lag by width+1 beats; the flush beats give the final W+1 results.
// configuration: cfg_index 0 = image width, 1 = image height, written between
// beats; cfg_ready is always high.
// per beat: accept with line memory read, then window update and write-back;
// a beat with a result then computes gradients, then squares, then the square
// root (8 result bits, then done), then loads the output register; a beat
// without a result ends after write-back, and an ignored flush at accept.
// the shared line memory (one read port, one write port) holds both stored
// lines, so one beat is in flight at a time.
// the output register lets a new input beat be taken while a result waits;
// if the receiver stalls, the next result holds until the register empties.
// reset: counters, window and state clear, width 1024, height 768; line
// memory is not cleared; stale contents read from it are masked to zero.
module sobel_edge_magnitude_rgb #(
  parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [sem_pkg::PIX_W-1:0]     in_red_in,
  input  logic [sem_pkg::PIX_W-1:0]     in_green_in,
  input  logic [sem_pkg::PIX_W-1:0]     in_blue_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sem_pkg::MAG_W-1:0]     out_red_edge,
  output logic [sem_pkg::MAG_W-1:0]     out_green_edge,
  output logic [sem_pkg::MAG_W-1:0]     out_blue_edge,
  output logic                          out_frame_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int XW = ((CW > sem_pkg::CFG_W_W) ? CW : sem_pkg::CFG_W_W) + 1;
  localparam int RW = sem_pkg::ROW_W + 1;
  localparam int PW = sem_pkg::PIX_W;
  localparam int GW = sem_pkg::GRAD_W;
  localparam int LW = 2 * sem_pkg::RGB_W;
  localparam logic [XW-1:0] MAX_W_X = XW'(MAX_WIDTH);

  sem_pkg::sem_state_t state_r, state_nxt;

  logic [sem_pkg::CFG_W_W-1:0] width_r;
  logic [sem_pkg::CFG_H_W-1:0] height_r;
  logic [CW-1:0]               in_col_r, in_col_nxt;
  logic [sem_pkg::ROW_W-1:0]   in_row_r, in_row_nxt;
  logic [CW-1:0]               out_col_r, out_col_nxt;
  logic [sem_pkg::ROW_W-1:0]   out_row_r, out_row_nxt;

  logic [LW-1:0]               line_mem [MAX_WIDTH];
  logic [LW-1:0]               line_rd_r;
  logic [CW-1:0]               col_r;
  logic [sem_pkg::RGB_W-1:0]   pix_r;
  logic                        res_r;
  logic                        last_r;
  logic [2:0]                  row_m_r;
  logic [2:0]                  col_m_r;
  logic [sem_pkg::RGB_W-1:0]   win_r [3][3];
  logic signed [GW-1:0]        gx_r [3];
  logic signed [GW-1:0]        gy_r [3];

  logic [sem_pkg::MAG_W-1:0]   red_r, green_r, blue_r;
  logic                        last_out_r;
  logic                        out_valid_r;

  logic [XW-1:0]               w_eff;
  logic [RW-1:0]               h_eff;
  logic                        accept;
  logic                        push;
  logic                        res_now;
  logic                        last_now;
  logic [2:0]                  row_m, col_m;
  logic                        win_en, grad_en, root_start, out_load;

  logic signed [GW-1:0]        gx [3];
  logic signed [GW-1:0]        gy [3];
  logic [sem_pkg::SUM_W-1:0]   sq_sum [3];
  logic                        root_busy [3];
  logic                        root_done [3];
  logic [sem_pkg::MAG_W-1:0]   root_val [3];

  // effective frame size
  always_comb begin
    if (width_r == '0) begin
      w_eff = XW'(1);
    end else if (XW'(width_r) > MAX_W_X) begin
      w_eff = MAX_W_X;
    end else begin
      w_eff = XW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = RW'(1);
    end else if (height_r > sem_pkg::MAX_HEIGHT) begin
      h_eff = RW'(sem_pkg::MAX_HEIGHT);
    end else begin
      h_eff = RW'(height_r);
    end
  end

  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // beat decode and position counters
  always_comb begin
    logic          pix_phase;
    logic          early;
    logic [XW-1:0] nc;
    logic [XW-1:0] oc;
    pix_phase   = RW'(in_row_r) < h_eff;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    push        = 1'b0;
    res_now     = 1'b0;
    last_now    = 1'b0;
    early       = (in_row_r == '0 && XW'(in_col_r) <= w_eff)
               || (in_row_r == sem_pkg::ROW_W'(1) && in_col_r == '0);
    nc          = XW'(in_col_r) + XW'(1);
    oc          = XW'(out_col_r) + XW'(1);
    row_m[0]    = out_row_r != '0;
    row_m[1]    = RW'(out_row_r) < h_eff;
    row_m[2]    = RW'(out_row_r) + RW'(1) < h_eff;
    col_m[0]    = out_col_r != '0;
    col_m[1]    = XW'(out_col_r) < w_eff;
    col_m[2]    = oc < w_eff;
    if (accept) begin
      if (pix_phase) begin
        push = in_action == sem_pkg::ACT_PIXEL;
      end else if (RW'(out_row_r) >= h_eff || RW'(in_row_r) > h_eff + RW'(1)) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else begin
        push = 1'b1;
      end
      if (push) begin
        if (nc >= w_eff) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + sem_pkg::ROW_W'(1);
        end else begin
          in_col_nxt = nc[CW-1:0];
        end
        if (!early) begin
          if (RW'(out_row_r) >= h_eff) begin
            in_col_nxt  = '0;
            in_row_nxt  = '0;
            out_col_nxt = '0;
            out_row_nxt = '0;
          end else begin
            res_now = 1'b1;
            if (RW'(out_row_r) == h_eff - RW'(1) && XW'(out_col_r) >= w_eff - XW'(1)) begin
              last_now    = 1'b1;
              in_col_nxt  = '0;
              in_row_nxt  = '0;
              out_col_nxt = '0;
              out_row_nxt = '0;
            end else if (oc >= w_eff) begin
              out_col_nxt = '0;
              out_row_nxt = out_row_r + sem_pkg::ROW_W'(1);
            end else begin
              out_col_nxt = oc[CW-1:0];
            end
          end
        end
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sem_pkg::ST_IDLE: if (accept && push) state_nxt = sem_pkg::ST_WIN;
      sem_pkg::ST_WIN:  state_nxt = res_r ? sem_pkg::ST_GRAD : sem_pkg::ST_IDLE;
      sem_pkg::ST_GRAD: state_nxt = sem_pkg::ST_SQR;
      sem_pkg::ST_SQR:  state_nxt = sem_pkg::ST_ROOT;
      sem_pkg::ST_ROOT: if (root_done[0]) state_nxt = sem_pkg::ST_OUT;
      sem_pkg::ST_OUT:  if (!out_valid_r || out_ready) state_nxt = sem_pkg::ST_IDLE;
      default:          state_nxt = sem_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready   = 1'b0;
    win_en     = 1'b0;
    grad_en    = 1'b0;
    root_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      sem_pkg::ST_IDLE: in_ready = 1'b1;
      sem_pkg::ST_WIN:  win_en = 1'b1;
      sem_pkg::ST_GRAD: grad_en = 1'b1;
      sem_pkg::ST_SQR:  root_start = 1'b1;
      sem_pkg::ST_ROOT: ;
      sem_pkg::ST_OUT:  out_load = !out_valid_r || out_ready;
      default:          ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sem_pkg::ST_IDLE;
      width_r     <= sem_pkg::WIDTH_RST;
      height_r    <= sem_pkg::HEIGHT_RST;
      in_col_r    <= '0;
      in_row_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sem_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_data[sem_pkg::CFG_W_W-1:0];
          sem_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_data[sem_pkg::CFG_H_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // line memory: {upper, middle} per column, read at accept, written back next cycle
  always_ff @(posedge clk) begin
    if (accept && push) begin
      line_rd_r <= line_mem[in_col_r];
    end
    if (win_en) begin
      line_mem[col_r] <= {line_rd_r[sem_pkg::RGB_W-1:0], pix_r};
    end
  end

  // beat payload
  always_ff @(posedge clk) begin
    if (accept && push) begin
      col_r   <= in_col_r;
      pix_r   <= (RW'(in_row_r) < h_eff) ? {in_red_in, in_green_in, in_blue_in} : '0;
      res_r   <= res_now;
      last_r  <= last_now;
      row_m_r <= row_m;
      col_m_r <= col_m;
    end
  end

  // window shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (win_en) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= line_rd_r[LW-1:sem_pkg::RGB_W];
      win_r[1][2] <= line_rd_r[sem_pkg::RGB_W-1:0];
      win_r[2][2] <= pix_r;
    end
  end

  // gradients per channel, neighbours outside the frame masked to zero
  always_comb begin
    logic [GW-1:0] v [3][3];
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          v[i][j] = (row_m_r[i] && col_m_r[j])
                  ? GW'(win_r[i][j][sem_pkg::RGB_W-1-PW*ch -: PW]) : '0;
        end
      end
      gx[ch] = signed'((v[0][2] + (v[1][2] << 1) + v[2][2])
                     - (v[0][0] + (v[1][0] << 1) + v[2][0]));
      gy[ch] = signed'((v[2][0] + (v[2][1] << 1) + v[2][2])
                     - (v[0][0] + (v[0][1] << 1) + v[0][2]));
    end
  end

  always_ff @(posedge clk) begin
    if (grad_en) begin
      for (int ch = 0; ch < 3; ch++) begin
        gx_r[ch] <= gx[ch];
        gy_r[ch] <= gy[ch];
      end
    end
  end

  always_comb begin
    logic signed [2*GW-1:0] px;
    logic signed [2*GW-1:0] py;
    for (int ch = 0; ch < 3; ch++) begin
      px         = gx_r[ch] * gx_r[ch];
      py         = gy_r[ch] * gy_r[ch];
      sq_sum[ch] = sem_pkg::SUM_W'(px) + sem_pkg::SUM_W'(py);
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_root
    sem_root u_root (
      .clk   (clk),
      .rst_n (rst_n),
      .start (root_start),
      .sum   (sq_sum[ch]),
      .busy  (root_busy[ch]),
      .done  (root_done[ch]),
      .root  (root_val[ch])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      red_r      <= root_val[0];
      green_r    <= root_val[1];
      blue_r     <= root_val[2];
      last_out_r <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red_edge   = red_r;
  assign out_green_edge = green_r;
  assign out_blue_edge  = blue_r;
  assign out_frame_last = last_out_r;

`ifndef SYNTHESIS
  a_root_idle: assert property (@(posedge clk) disable iff (!rst_n)
    root_start |-> !root_busy[0])
    else $error("root unit started while busy");

  a_root_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    root_done[0] |-> (state_r == sem_pkg::ST_ROOT))
    else $error("root result outside root state");

  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == sem_pkg::ST_WIN || state_r == sem_pkg::ST_IDLE))
    else $error("unexpected state after accepted beat");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid)
    else $error("loaded result not presented");
`endif

endmodule

@@ hw/rtl/sem_root.sv @@
// iterative rounded square root, one result bit per cycle
module sem_root (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sem_pkg::SUM_W-1:0] sum,
  output logic                      busy,
  output logic                      done,
  output logic [sem_pkg::MAG_W-1:0] root
);

  logic [sem_pkg::SUM_W-1:0]   sum_r;
  logic [sem_pkg::MAG_W-1:0]   n_r;
  logic [sem_pkg::MAG_W-1:0]   bit_r;
  logic                        busy_r;
  logic                        done_r;
  logic [sem_pkg::MAG_W-1:0]   cand;
  logic [2*sem_pkg::MAG_W-1:0] prod;
  logic                        hit;

  always_comb begin
    cand = n_r | bit_r;
    prod = (2*sem_pkg::MAG_W)'(cand * cand) - {{sem_pkg::MAG_W{1'b0}}, cand};
    hit  = {{(sem_pkg::SUM_W-2*sem_pkg::MAG_W){1'b0}}, prod} < sum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sum_r <= sum;
      n_r   <= '0;
      bit_r <= {1'b1, {(sem_pkg::MAG_W-1){1'b0}}};
    end else if (busy_r) begin
      if (hit) begin
        n_r <= cand;
      end
      bit_r <= bit_r >> 1;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = n_r;

endmodule

@@ verif/sobel_edge_magnitude_rgb_tb.sv @@
// testbench for the rgb sobel edge magnitude block: self-checking stream test
`timescale 1ns / 1ps

module sobel_edge_magnitude_rgb_tb;

  typedef struct packed {
    logic                      action;
    logic [sem_pkg::PIX_W-1:0] red;
    logic [sem_pkg::PIX_W-1:0] green;
    logic [sem_pkg::PIX_W-1:0] blue;
  } pix_beat_t;

  typedef struct packed {
    logic [sem_pkg::MAG_W-1:0] red;
    logic [sem_pkg::MAG_W-1:0] green;
    logic [sem_pkg::MAG_W-1:0] blue;
    logic                      last;
  } edge_res_t;

  localparam int WATCHDOG_LIMIT = 5000;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           in_action = sem_pkg::ACT_PIXEL;
  logic [sem_pkg::PIX_W-1:0]      in_red_in = '0;
  logic [sem_pkg::PIX_W-1:0]      in_green_in = '0;
  logic [sem_pkg::PIX_W-1:0]      in_blue_in = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [sem_pkg::MAG_W-1:0]      out_red_edge;
  logic [sem_pkg::MAG_W-1:0]      out_green_edge;
  logic [sem_pkg::MAG_W-1:0]      out_blue_edge;
  logic                           out_frame_last;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index = sem_pkg::CFG_IMAGE_WIDTH;
  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  pix_beat_t pixel_beats[$];
  edge_res_t edge_expect[$];
  int        fail_count = 0;
  int        items_sent = 0;
  int        idle_cycles = 0;
  int        in_gap = 0;
  int        out_stall = 0;
  bit        calm = 1'b0;

  // predictor state
  logic [sem_pkg::CFG_W_W-1:0] img_width = sem_pkg::WIDTH_RST;
  logic [sem_pkg::CFG_H_W-1:0] img_height = sem_pkg::HEIGHT_RST;
  logic [sem_pkg::RGB_W-1:0]   top_store[sem_pkg::MAX_WIDTH_DEF];
  logic [sem_pkg::RGB_W-1:0]   mid_store[sem_pkg::MAX_WIDTH_DEF];
  logic [sem_pkg::RGB_W-1:0]   win[3][3];
  int                          in_col, in_row, out_col, out_row;

  sobel_edge_magnitude_rgb DUT (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [sem_pkg::MAG_W-1:0] round_root(longint sum);
    int n;
    int c;
    n = 0;
    for (int b = 128; b != 0; b >>= 1) begin
      c = n | b;
      if (longint'(c) * c - c < sum) n = c;
    end
    return sem_pkg::MAG_W'(n);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic reset_counters();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endtask

  task automatic sobel_predict(input pix_beat_t b, output bit got, output edge_res_t res);
    int w, h, rr, cc, gx, gy, v, sh;
    logic [sem_pkg::RGB_W-1:0] pix;
    longint pos;
    int kx[3][3];
    int ky[3][3];
    logic [sem_pkg::MAG_W-1:0] mag[3];
    kx = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
    ky = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};
    got = 1'b0;
    res = '0;
    pix = '0;
    w = (img_width == 0) ? 1 : ((img_width > sem_pkg::MAX_WIDTH_DEF)
        ? sem_pkg::MAX_WIDTH_DEF : int'(img_width));
    h = (img_height == 0) ? 1 : ((img_height > sem_pkg::MAX_HEIGHT)
        ? int'(sem_pkg::MAX_HEIGHT) : int'(img_height));
    if (in_row < h) begin
      if (b.action == sem_pkg::ACT_FLUSH) return;
      pix = {b.red, b.green, b.blue};
    end else if (out_row >= h || in_row > h + 1) begin
      reset_counters();
      return;
    end
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = top_store[in_col];
    win[1][2] = mid_store[in_col];
    top_store[in_col] = mid_store[in_col];
    mid_store[in_col] = pix;
    win[2][2] = pix;
    pos = longint'(in_row) * w + in_col;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (pos < w + 1) return;
    if (out_row >= h) begin
      reset_counters();
      return;
    end
    for (int ch = 0; ch < 3; ch++) begin
      gx = 0;
      gy = 0;
      sh = 16 - 8 * ch;
      for (int i = 0; i < 3; i++) begin
        rr = out_row - 1 + i;
        if (rr < 0 || rr >= h) continue;
        for (int j = 0; j < 3; j++) begin
          cc = out_col - 1 + j;
          if (cc < 0 || cc >= w) continue;
          v = int'((win[i][j] >> sh) & 24'hFF);
          gx += kx[i][j] * v;
          gy += ky[i][j] * v;
        end
      end
      mag[ch] = round_root(longint'(gx) * gx + longint'(gy) * gy);
    end
    res.red = mag[0];
    res.green = mag[1];
    res.blue = mag[2];
    got = 1'b1;
    if (out_row == h - 1 && out_col >= w - 1) begin
      res.last = 1'b1;
      reset_counters();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  // input driver
  always @(posedge clk) begin
    bit        got;
    edge_res_t res;
    pix_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        sobel_predict({in_action, in_red_in, in_green_in, in_blue_in}, got, res);
        if (got) edge_expect.push_back(res);
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pixel_beats.size() > 0) begin
          nxt = pixel_beats.pop_front();
          in_valid <= 1'b1;
          in_action <= nxt.action;
          in_red_in <= nxt.red;
          in_green_in <= nxt.green;
          in_blue_in <= nxt.blue;
          in_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    edge_res_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (edge_expect.size() == 0) begin
        $error("unexpected result beat");
        fail_count++;
      end else begin
        exp_res = edge_expect.pop_front();
        if (out_red_edge !== exp_res.red) begin
          $error("red_edge expected %0d got %0d", exp_res.red, out_red_edge);
          fail_count++;
        end
        if (out_green_edge !== exp_res.green) begin
          $error("green_edge expected %0d got %0d", exp_res.green, out_green_edge);
          fail_count++;
        end
        if (out_blue_edge !== exp_res.blue) begin
          $error("blue_edge expected %0d got %0d", exp_res.blue, out_blue_edge);
          fail_count++;
        end
        if (out_frame_last !== exp_res.last) begin
          $error("frame_last expected %0d got %0d", exp_res.last, out_frame_last);
          fail_count++;
        end
      end
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_stall = pick_gap();
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sobel_edge_magnitude_rgb test failed");
      $finish;
    end
  end

  task automatic push_beat(input logic act, input logic [23:0] rgb);
    pixel_beats.push_back({act, rgb});
    items_sent++;
  endtask

  task automatic settle();
    while (pixel_beats.size() > 0 || in_valid || edge_expect.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sem_pkg::CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= sem_pkg::CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    if (idx == sem_pkg::CFG_IMAGE_WIDTH) img_width = sem_pkg::CFG_W_W'(value);
    else if (idx == sem_pkg::CFG_IMAGE_HEIGHT) img_height = sem_pkg::CFG_H_W'(value);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [23:0] rand_pixel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 24'h000000;
    if (r == 1) return 24'hFFFFFF;
    if (r == 2) return {3{8'($urandom_range(0, 1) * 255)}};
    return 24'($urandom);
  endfunction

  // one frame of w x h pixels; noisy frames carry ignored flushes and
  // pixels standing in for flushes while draining
  task automatic push_frame(input int w, input int h, input bit noisy);
    for (int i = 0; i < w * h; i++) begin
      if (noisy && $urandom_range(0, 9) == 0) push_beat(sem_pkg::ACT_FLUSH, 24'($urandom));
      push_beat(sem_pkg::ACT_PIXEL, rand_pixel());
    end
    for (int i = 0; i <= w; i++) begin
      if (noisy && $urandom_range(0, 2) == 0) push_beat(sem_pkg::ACT_PIXEL, 24'($urandom));
      else push_beat(sem_pkg::ACT_FLUSH, 24'($urandom));
    end
    if (noisy && $urandom_range(0, 3) == 0) push_beat(sem_pkg::ACT_FLUSH, 24'($urandom));
  endtask

  initial begin
    int w, h;
    for (int i = 0; i < sem_pkg::MAX_WIDTH_DEF; i++) begin
      top_store[i] = '0;
      mid_store[i] = '0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    reset_counters();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // zero sizes act as one pixel
    write_reg(sem_pkg::CFG_IMAGE_WIDTH, 0);
    write_reg(sem_pkg::CFG_IMAGE_HEIGHT, 0);
    push_beat(sem_pkg::ACT_FLUSH, 24'h000000);
    push_beat(sem_pkg::ACT_PIXEL, 24'hFFFFFF);
    push_beat(sem_pkg::ACT_FLUSH, 24'h000000);
    push_beat(sem_pkg::ACT_PIXEL, 24'h000000);
    push_beat(sem_pkg::ACT_FLUSH, 24'h000000);
    settle();
    // 3x3 frame with full-swing content
    write_reg(sem_pkg::CFG_IMAGE_WIDTH, 3);
    write_reg(sem_pkg::CFG_IMAGE_HEIGHT, 3);
    push_beat(sem_pkg::ACT_PIXEL, 24'hFFFFFF);
    push_beat(sem_pkg::ACT_PIXEL, 24'h000000);
    push_beat(sem_pkg::ACT_PIXEL, 24'hFF00FF);
    push_beat(sem_pkg::ACT_PIXEL, 24'h00FF00);
    push_beat(sem_pkg::ACT_PIXEL, 24'hFFFFFF);
    push_beat(sem_pkg::ACT_FLUSH, 24'h000000);
    push_beat(sem_pkg::ACT_PIXEL, 24'h000000);
    push_beat(sem_pkg::ACT_PIXEL, 24'hFFFFFF);
    push_beat(sem_pkg::ACT_PIXEL, 24'h0000FF);
    push_beat(sem_pkg::ACT_PIXEL, 24'hFFFF00);
    push_beat(sem_pkg::ACT_PIXEL, 24'h123456);
    push_beat(sem_pkg::ACT_PIXEL, 24'hFFFFFF);
    push_beat(sem_pkg::ACT_FLUSH, 24'h000000);
    push_beat(sem_pkg::ACT_FLUSH, 24'h000000);
    settle();

    // out-of-range height, cut short once the pipeline is empty
    write_reg(sem_pkg::CFG_IMAGE_WIDTH, 1);
    write_reg(sem_pkg::CFG_IMAGE_HEIGHT, 8191);
    repeat (5) push_beat(sem_pkg::ACT_PIXEL, rand_pixel());
    settle();
    write_reg(sem_pkg::CFG_IMAGE_HEIGHT, 5);
    push_beat(sem_pkg::ACT_FLUSH, 24'h000000);
    push_beat(sem_pkg::ACT_PIXEL, 24'hFFFFFF);
    push_beat(sem_pkg::ACT_FLUSH, 24'h000000);
    settle();

    while (items_sent < 1450) begin
      calm = ($urandom_range(0, 5) == 0);
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      write_reg(sem_pkg::CFG_IMAGE_WIDTH, w);
      write_reg(sem_pkg::CFG_IMAGE_HEIGHT, h);
      repeat ($urandom_range(1, 3)) push_frame(w, h, $urandom_range(0, 2) == 0);
      settle();
    end
    calm = 1'b0;
    settle();

    if (fail_count == 0)
      $display("sobel_edge_magnitude_rgb test passed");
    else
      $display("sobel_edge_magnitude_rgb test failed");
    $finish;
  end

endmodule

@@ sobel_edge_magnitude_rgb.f @@
hw/rtl/sem_pkg.sv
hw/rtl/sem_root.sv
hw/rtl/sobel_edge_magnitude_rgb.sv
verif/sobel_edge_magnitude_rgb_tb.sv
